/* hdl/gso3_pkg.sv */
// Package for the 3x3 Gram-Schmidt orthonormalization unit.
// Holds the transaction payload structs, fixed-point widths and shared helpers.
// No dependencies.
package gso3_pkg;

    localparam int QBITS  = 14;
    localparam int SQ_W   = 34;   // exact sum of three squares of 16-bit values
    localparam int LEN_W  = 17;   // floor sqrt of SQ_W bits
    localparam int NUM_W  = 30;   // 16-bit value shifted left by QBITS
    localparam int QUO_W  = 30;   // raw quotient magnitude width

    typedef struct packed {
        logic signed [15:0] in_r0c0;
        logic signed [15:0] in_r0c1;
        logic signed [15:0] in_r0c2;
        logic signed [15:0] in_r1c0;
        logic signed [15:0] in_r1c1;
        logic signed [15:0] in_r1c2;
        logic signed [15:0] in_r2c0;
        logic signed [15:0] in_r2c1;
        logic signed [15:0] in_r2c2;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_r0c0;
        logic signed [15:0] out_r0c1;
        logic signed [15:0] out_r0c2;
        logic signed [15:0] out_r1c0;
        logic signed [15:0] out_r1c1;
        logic signed [15:0] out_r1c2;
        logic signed [15:0] out_r2c0;
        logic signed [15:0] out_r2c1;
        logic signed [15:0] out_r2c2;
        logic               degenerate;
    } out_item_t;

    typedef logic signed [15:0] vec3_t [3];

    // Saturate a wide signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767)
            r = 16'sh7fff;
        else if (v < -48'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Floor shift by QBITS then saturate.
    function automatic logic signed [15:0] floor_sat(input logic signed [47:0] v);
        logic signed [47:0] s;
        s = v >>> QBITS;
        return sat16(s);
    endfunction

endpackage

/* hdl/gso3_delay.sv */
// Register delay line used to align data beside the pipelined units.
// Depends on nothing but its parameters.
module gso3_delay #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] stage_reg [DEPTH];

    // shift line
    always_ff @(posedge clk)
    begin
        stage_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            stage_reg[i] <= stage_reg[i-1];
        end
    end

    assign dout = stage_reg[DEPTH-1];
endmodule

/* hdl/gso3_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
// Depends on gso3_pkg for widths.
module gso3_sqrt (
    input  logic                       clk,
    input  logic [gso3_pkg::SQ_W-1:0]  rad,
    output logic [gso3_pkg::LEN_W-1:0] root
);
    localparam int N  = gso3_pkg::LEN_W;
    localparam int RW = gso3_pkg::SQ_W + 2;

    logic [RW-1:0] rem_reg [N];
    logic [N-1:0]  res_reg [N];
    logic [RW-1:0] x_reg   [N];

    // each stage decides one root bit, MSB first
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < N; s++)
        begin
            logic [RW-1:0] rin;
            logic [N-1:0]  qin;
            logic [RW-1:0] xin;
            logic [RW-1:0] trial;
            logic [RW-1:0] cur;
            if (s == 0)
            begin
                rin = '0;
                qin = '0;
                xin = {2'b00, rad};
            end
            else
            begin
                rin = rem_reg[s-1];
                qin = res_reg[s-1];
                xin = x_reg[s-1];
            end
            cur   = (rin << 2) | RW'((xin >> (2 * (N - 1 - s))) & RW'(3));
            trial = (RW'(qin) << 2) | RW'(1);
            if (cur >= trial)
            begin
                rem_reg[s] <= cur - trial;
                res_reg[s] <= (qin << 1) | N'(1);
            end
            else
            begin
                rem_reg[s] <= cur;
                res_reg[s] <= qin << 1;
            end
            x_reg[s] <= xin;
        end
    end

    assign root = res_reg[N-1];
endmodule

/* hdl/gso3_lane.sv */
// One column lane: exact squared length, floor sqrt, three pipelined divisions.
// Depends on gso3_pkg, gso3_sqrt and gso3_delay.
module gso3_lane (
    input  logic               clk,
    input  logic signed [15:0] v0,
    input  logic signed [15:0] v1,
    input  logic signed [15:0] v2,
    output logic signed [15:0] q0,
    output logic signed [15:0] q1,
    output logic signed [15:0] q2,
    output logic               zero_len
);
    localparam int LW  = gso3_pkg::LEN_W;
    localparam int QW  = gso3_pkg::QUO_W;

    logic [31:0] sq0_reg, sq1_reg, sq2_reg;
    logic [gso3_pkg::SQ_W-1:0] sum_reg;
    logic [LW-1:0] len;
    logic [47:0] vin, vd;
    logic signed [15:0] a0, a1, a2;

    // exact squares, then sum
    always_ff @(posedge clk)
    begin
        sq0_reg <= 32'(v0 * v0);
        sq1_reg <= 32'(v1 * v1);
        sq2_reg <= 32'(v2 * v2);
        sum_reg <= 34'(sq0_reg) + 34'(sq1_reg) + 34'(sq2_reg);
    end

    gso3_sqrt u_sqrt (.clk(clk), .rad(sum_reg), .root(len));

    assign vin = {v0, v1, v2};
    gso3_delay #(.WIDTH(48), .DEPTH(2 + LW)) u_dly (.clk(clk), .din(vin), .dout(vd));
    assign a0 = vd[47:32];
    assign a1 = vd[31:16];
    assign a2 = vd[15:0];

    // restoring dividers, one quotient bit per stage, three side by side
    logic [QW-1:0] n_reg [3][QW];
    logic [QW-1:0] r_reg [3][QW];
    logic [QW-1:0] qq_reg[3][QW];
    logic          sg_reg[3][QW];
    logic [LW-1:0] d_reg [QW];
    logic signed [15:0] res_reg [3];
    logic zero_reg;

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QW; s++)
        begin
            logic [LW-1:0] din;
            din = (s == 0) ? len : d_reg[s-1];
            d_reg[s] <= din;
            for (int k = 0; k < 3; k++)
            begin
                logic [QW-1:0] nin, rin, qin, rsh;
                logic          sin;
                logic signed [15:0] a;
                a = (k == 0) ? a0 : ((k == 1) ? a1 : a2);
                if (s == 0)
                begin
                    sin = a[15];
                    nin = QW'(a[15] ? -32'(a) : 32'(a)) << gso3_pkg::QBITS;
                    rin = '0;
                    qin = '0;
                end
                else
                begin
                    sin = sg_reg[k][s-1];
                    nin = n_reg[k][s-1];
                    rin = r_reg[k][s-1];
                    qin = qq_reg[k][s-1];
                end
                rsh = (rin << 1) | QW'(nin[QW-1-s]);
                if (rsh >= QW'(din))
                begin
                    r_reg[k][s]  <= rsh - QW'(din);
                    qq_reg[k][s] <= (qin << 1) | QW'(1);
                end
                else
                begin
                    r_reg[k][s]  <= rsh;
                    qq_reg[k][s] <= qin << 1;
                end
                n_reg[k][s]  <= nin;
                sg_reg[k][s] <= sin;
            end
        end
        // sign and saturate
        for (int k = 0; k < 3; k++)
        begin
            logic signed [47:0] m;
            m = 48'(qq_reg[k][QW-1]);
            res_reg[k] <= gso3_pkg::sat16(sg_reg[k][QW-1] ? -m : m);
        end
        zero_reg <= (d_reg[QW-1] == '0);
    end

    assign q0 = res_reg[0];
    assign q1 = res_reg[1];
    assign q2 = res_reg[2];
    assign zero_len = zero_reg;
endmodule

/* hdl/gram_schmidt_orthonormalize_3x3_unit.sv */
// 3x3 Gram-Schmidt orthonormalization unit, signed Q2.14.
// Pipeline: 3 lanes, 3 projection stages each for columns 1 and 2 and one output
// register; done is registered beside the result.
// Throughput: one transaction per cycle; busy is always low and the receiver
// cannot stall. Reset clears the valid pipe.
// Depends on gso3_pkg, gso3_lane, gso3_delay.
module gram_schmidt_orthonormalize_3x3_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gso3_pkg::in_item_t   in_item,
    output logic                 done,
    output gso3_pkg::out_item_t  result
);
    localparam int LAT = 2 + gso3_pkg::LEN_W + gso3_pkg::QUO_W + 1;  // lane latency
    localparam int PL  = 3;                           // projection stages
    localparam int TOT = 3 * LAT + 2 * PL + 1;

    assign busy = 1'b0;

    // lane 0 on column 0
    logic signed [15:0] qa0, qa1, qa2;
    logic z0;
    gso3_lane u_lane0 (.clk(clk), .v0(in_item.in_r0c0), .v1(in_item.in_r1c0),
                       .v2(in_item.in_r2c0), .q0(qa0), .q1(qa1), .q2(qa2), .zero_len(z0));

    // hold columns 1,2 beside lane 0
    logic [95:0] c12_in, c12_d;
    assign c12_in = {in_item.in_r0c1, in_item.in_r1c1, in_item.in_r2c1,
                     in_item.in_r0c2, in_item.in_r1c2, in_item.in_r2c2};
    gso3_delay #(.WIDTH(96), .DEPTH(LAT)) u_d12 (.clk(clk), .din(c12_in), .dout(c12_d));

    // projection of column 1 on q0
    logic signed [15:0] m1 [3];
    logic signed [47:0] p1_reg [3];
    logic signed [15:0] d0_reg, w1_reg [3];
    logic signed [15:0] qa_s1 [3], qa_s2 [3];
    logic signed [15:0] m1_s1 [3], m1_s2 [3];
    assign m1[0] = c12_d[95:80];
    assign m1[1] = c12_d[79:64];
    assign m1[2] = c12_d[63:48];

    always_ff @(posedge clk)
    begin
        p1_reg[0] <= 48'(qa0 * m1[0]);
        p1_reg[1] <= 48'(qa1 * m1[1]);
        p1_reg[2] <= 48'(qa2 * m1[2]);
        qa_s1[0] <= qa0; qa_s1[1] <= qa1; qa_s1[2] <= qa2;
        m1_s1 <= m1;
        d0_reg <= gso3_pkg::floor_sat(p1_reg[0] + p1_reg[1] + p1_reg[2]);
        qa_s2 <= qa_s1;
        m1_s2 <= m1_s1;
        for (int r = 0; r < 3; r++)
        begin
            w1_reg[r] <= gso3_pkg::floor_sat((48'(m1_s2[r]) <<< gso3_pkg::QBITS)
                                             - 48'(d0_reg * qa_s2[r]));
        end
    end

    // lane 1 on w1
    logic signed [15:0] qb0, qb1, qb2;
    logic z1;
    gso3_lane u_lane1 (.clk(clk), .v0(w1_reg[0]), .v1(w1_reg[1]), .v2(w1_reg[2]),
                       .q0(qb0), .q1(qb1), .q2(qb2), .zero_len(z1));

    // q0, z0 and column 2 aligned to lane 1 output
    logic [48:0] qa_in, qa_d;
    logic [47:0] m2_in, m2_d;
    assign qa_in = {z0, qa0, qa1, qa2};
    assign m2_in = c12_d[47:0];
    gso3_delay #(.WIDTH(49), .DEPTH(LAT + PL)) u_dqa (.clk(clk), .din(qa_in), .dout(qa_d));
    gso3_delay #(.WIDTH(48), .DEPTH(LAT + PL)) u_dm2 (.clk(clk), .din(m2_in), .dout(m2_d));

    // projections of column 2 on q0 and q1
    logic signed [15:0] qa_c [3], qb_c [3], m2 [3];
    logic signed [47:0] pa_reg [3], pb_reg [3];
    logic signed [15:0] da_reg, db_reg, w2_reg [3];
    logic signed [15:0] qa_t1 [3], qb_t1 [3], m2_t1 [3];
    logic signed [15:0] qa_t2 [3], qb_t2 [3], m2_t2 [3];
    assign qa_c[0] = qa_d[47:32]; assign qa_c[1] = qa_d[31:16]; assign qa_c[2] = qa_d[15:0];
    assign qb_c[0] = qb0; assign qb_c[1] = qb1; assign qb_c[2] = qb2;
    assign m2[0] = m2_d[47:32]; assign m2[1] = m2_d[31:16]; assign m2[2] = m2_d[15:0];

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            pa_reg[r] <= 48'(qa_c[r] * m2[r]);
            pb_reg[r] <= 48'(qb_c[r] * m2[r]);
        end
        qa_t1 <= qa_c; qb_t1 <= qb_c; m2_t1 <= m2;
        da_reg <= gso3_pkg::floor_sat(pa_reg[0] + pa_reg[1] + pa_reg[2]);
        db_reg <= gso3_pkg::floor_sat(pb_reg[0] + pb_reg[1] + pb_reg[2]);
        qa_t2 <= qa_t1; qb_t2 <= qb_t1; m2_t2 <= m2_t1;
        for (int r = 0; r < 3; r++)
        begin
            w2_reg[r] <= gso3_pkg::floor_sat((48'(m2_t2[r]) <<< gso3_pkg::QBITS)
                         - 48'(da_reg * qa_t2[r]) - 48'(db_reg * qb_t2[r]));
        end
    end

    // lane 2 on w2
    logic signed [15:0] qc0, qc1, qc2;
    logic z2;
    gso3_lane u_lane2 (.clk(clk), .v0(w2_reg[0]), .v1(w2_reg[1]), .v2(w2_reg[2]),
                       .q0(qc0), .q1(qc1), .q2(qc2), .zero_len(z2));

    // align q0, q1 to lane 2 output
    logic [48:0] qab_in, qab_d;
    logic [48:0] qf_d;
    assign qab_in = {z1, qb0, qb1, qb2};
    gso3_delay #(.WIDTH(49), .DEPTH(LAT + PL)) u_dqb (.clk(clk), .din(qab_in), .dout(qab_d));
    gso3_delay #(.WIDTH(49), .DEPTH(LAT + PL)) u_dqf (.clk(clk), .din(qa_d), .dout(qf_d));

    // merge stage and valid pipe
    logic [TOT-2:0] vld_reg;
    logic           done_reg;
    gso3_pkg::out_item_t res_reg;
    logic degen;
    assign degen = qf_d[48] | qab_d[48] | z2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[TOT-3:0], start};
            done_reg <= vld_reg[TOT-2];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg.out_r0c0 <= degen ? '0 : qf_d[47:32];
        res_reg.out_r1c0 <= degen ? '0 : qf_d[31:16];
        res_reg.out_r2c0 <= degen ? '0 : qf_d[15:0];
        res_reg.out_r0c1 <= degen ? '0 : qab_d[47:32];
        res_reg.out_r1c1 <= degen ? '0 : qab_d[31:16];
        res_reg.out_r2c1 <= degen ? '0 : qab_d[15:0];
        res_reg.out_r0c2 <= degen ? '0 : qc0;
        res_reg.out_r1c2 <= degen ? '0 : qc1;
        res_reg.out_r2c2 <= degen ? '0 : qc2;
        res_reg.degenerate <= degen;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

/* verif/gram_schmidt_orthonormalize_3x3_unit_test.sv */
// Self-checking test of the 3x3 Gram-Schmidt orthonormalization unit.
// Drives matrix transactions, predicts each result with a fixed-point model.
// Depends on gso3_pkg and gram_schmidt_orthonormalize_3x3_unit.
`timescale 1ns / 1ps

module gram_schmidt_orthonormalize_3x3_unit_test;

    localparam int N_RANDOM    = 1200;
    localparam int LATENCY     = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 12;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    gso3_pkg::in_item_t   in_item;
    logic                 done;
    gso3_pkg::out_item_t  result;

    gso3_pkg::out_item_t pending_q[$];
    int          mismatches;
    int          sent;
    int          received;
    int          degen_seen;
    longint      cycles;

    gram_schmidt_orthonormalize_3x3_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact integer helpers at 64 bits
    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint floor14(input longint v);
        return v >>> gso3_pkg::QBITS;
    endfunction

    function automatic longint root_floor(input longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x)
            b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint vec_len(input longint a0, input longint a1, input longint a2);
        return root_floor(a0 * a0 + a1 * a1 + a2 * a2);
    endfunction

    // SV division truncates toward zero, matching C
    function automatic longint unit_entry(input longint v, input longint len);
        return clamp16((v * 16384) / len);
    endfunction

    function automatic gso3_pkg::out_item_t orthonormalize(input gso3_pkg::in_item_t x);
        gso3_pkg::out_item_t o;
        longint m[3][3];
        longint q[3][3];
        longint w[3];
        longint len;
        longint d0;
        longint d1;
        bit     degen;
        m[0][0] = x.in_r0c0; m[1][0] = x.in_r0c1; m[2][0] = x.in_r0c2;
        m[0][1] = x.in_r1c0; m[1][1] = x.in_r1c1; m[2][1] = x.in_r1c2;
        m[0][2] = x.in_r2c0; m[1][2] = x.in_r2c1; m[2][2] = x.in_r2c2;
        degen = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                q[i][j] = 0;
        len = vec_len(m[0][0], m[0][1], m[0][2]);
        if (len == 0)
            degen = 1'b1;
        else
            for (int r = 0; r < 3; r++)
                q[0][r] = unit_entry(m[0][r], len);
        if (!degen)
        begin
            d0 = clamp16(floor14(q[0][0] * m[1][0] + q[0][1] * m[1][1] + q[0][2] * m[1][2]));
            for (int r = 0; r < 3; r++)
                w[r] = clamp16(floor14(m[1][r] * 16384 - d0 * q[0][r]));
            len = vec_len(w[0], w[1], w[2]);
            if (len == 0)
                degen = 1'b1;
            else
                for (int r = 0; r < 3; r++)
                    q[1][r] = unit_entry(w[r], len);
        end
        if (!degen)
        begin
            d0 = clamp16(floor14(q[0][0] * m[2][0] + q[0][1] * m[2][1] + q[0][2] * m[2][2]));
            d1 = clamp16(floor14(q[1][0] * m[2][0] + q[1][1] * m[2][1] + q[1][2] * m[2][2]));
            for (int r = 0; r < 3; r++)
                w[r] = clamp16(floor14(m[2][r] * 16384 - d0 * q[0][r] - d1 * q[1][r]));
            len = vec_len(w[0], w[1], w[2]);
            if (len == 0)
                degen = 1'b1;
            else
                for (int r = 0; r < 3; r++)
                    q[2][r] = unit_entry(w[r], len);
        end
        if (degen)
            o = '0;
        else
        begin
            o.out_r0c0 = 16'(q[0][0]); o.out_r0c1 = 16'(q[1][0]); o.out_r0c2 = 16'(q[2][0]);
            o.out_r1c0 = 16'(q[0][1]); o.out_r1c1 = 16'(q[1][1]); o.out_r1c2 = 16'(q[2][1]);
            o.out_r2c0 = 16'(q[0][2]); o.out_r2c1 = 16'(q[1][2]); o.out_r2c2 = 16'(q[2][2]);
        end
        o.degenerate = degen;
        return o;
    endfunction

    function automatic gso3_pkg::in_item_t make_item(
        input logic signed [15:0] a, input logic signed [15:0] b,
        input logic signed [15:0] c, input logic signed [15:0] d,
        input logic signed [15:0] e, input logic signed [15:0] f,
        input logic signed [15:0] g, input logic signed [15:0] h,
        input logic signed [15:0] k);
        return {a, b, c, d, e, f, g, h, k};
    endfunction

    // Random entry: full range, small values, extremes
    function automatic logic signed [15:0] rand_entry();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3, 4:    return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic gso3_pkg::in_item_t rand_item();
        gso3_pkg::in_item_t x;
        x = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
             rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        // Sometimes make columns dependent to hit degenerate paths
        case ($urandom_range(0, 15))
            0:
            begin
                x.in_r0c1 = x.in_r0c0; x.in_r1c1 = x.in_r1c0; x.in_r2c1 = x.in_r2c0;
            end
            1:
            begin
                x.in_r0c2 = x.in_r0c1; x.in_r1c2 = x.in_r1c1; x.in_r2c2 = x.in_r2c1;
            end
            2:
            begin
                x.in_r0c0 = '0; x.in_r1c0 = '0; x.in_r2c0 = '0;
            end
            default: ;
        endcase
        return x;
    endfunction

    // Issue one transaction at the falling edge, wait for acceptance
    task automatic send_matrix(input gso3_pkg::in_item_t x, input bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        in_item <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_q.push_back(orthonormalize(x));
        sent++;
        @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        gso3_pkg::out_item_t exp_r;
        if (rst_n && done)
        begin
            received++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                exp_r = pending_q.pop_front();
                if (exp_r.degenerate)
                    degen_seen++;
                if (result !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: expected %h got %h", received, exp_r, result);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** gram_schmidt_orthonormalize_3x3_unit: FAILED **");
            $finish;
        end
    end

    gso3_pkg::in_item_t  dir_item[N_DIRECTED];
    gso3_pkg::out_item_t dir_exp[N_DIRECTED];
    bit                  dir_fixed[N_DIRECTED];

    initial
    begin
        int waited;
        gso3_pkg::out_item_t degen_out;
        start      = 1'b0;
        in_item    = '0;
        rst_n      = 1'b0;
        mismatches = 0;
        sent       = 0;
        received   = 0;
        degen_seen = 0;
        cycles     = 0;
        degen_out  = '0;
        degen_out.degenerate = 1'b1;

        // Directed table; fixed expectations only where obvious
        dir_item[0]  = '0;
        dir_item[1]  = make_item(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
        dir_item[2]  = make_item(16384, 16384, 0, 0, 0, 0, 0, 0, 16384);
        dir_item[3]  = make_item(16384, 0, 0, 0, 16384, 0, 0, 0, 0);
        dir_item[4]  = {9{16'sh7fff}};
        dir_item[5]  = {9{16'sh8000}};
        dir_item[6]  = make_item(-32768, 0, 0, 0, 32767, 0, 0, 0, -32768);
        dir_item[7]  = make_item(1, 0, 0, 0, 1, 0, 0, 0, 1);
        dir_item[8]  = make_item(32767, -32768, 1, -32768, 32767, -1, 1, 1, 32767);
        dir_item[9]  = make_item(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        dir_item[10] = make_item(0, 16384, 0, 16384, 0, 0, 0, 0, -16384);
        dir_item[11] = make_item(12000, -5000, 300, 7000, 9000, -20000, -3000, 15000, 4000);
        for (int i = 0; i < N_DIRECTED; i++)
            dir_fixed[i] = 1'b0;
        dir_exp[0] = degen_out;    dir_fixed[0] = 1'b1;
        dir_exp[1] = make_item(16384, 0, 0, 0, 16384, 0, 0, 0, 16384) << 1;
        dir_fixed[1] = 1'b1;
        dir_exp[2] = degen_out;    dir_fixed[2] = 1'b1;
        dir_exp[3] = degen_out;    dir_fixed[3] = 1'b1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_matrix(dir_item[i], 1'b1);
            if (dir_fixed[i] && orthonormalize(dir_item[i]) !== dir_exp[i])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: predictor %h vs table %h", i,
                             orthonormalize(dir_item[i]), dir_exp[i]);
            end
        end

        // Random part; last quarter back to back
        for (int i = 0; i < N_RANDOM; i++)
            send_matrix(rand_item(), i < (N_RANDOM * 3) / 4);
        start <= 1'b0;

        waited = 0;
        while (pending_q.size() != 0 && waited < 20 * LATENCY)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY) @(posedge clk);

        $display("sent %0d matrices, checked %0d results, %0d degenerate", sent, received,
                 degen_seen);
        $display("mismatches: %0d, left over: %0d", mismatches, pending_q.size());
        if (mismatches == 0 && pending_q.size() == 0)
            $display("** gram_schmidt_orthonormalize_3x3_unit: PASSED **");
        else
            $display("** gram_schmidt_orthonormalize_3x3_unit: FAILED **");
        $finish;
    end

endmodule
